// ===== src/plm_pkg.sv =====
`default_nettype none
package plm_pkg;

	// queue geometry and field widths
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int BURST_LIMIT = 8;
	localparam int CNT_W = $clog2(BURST_LIMIT + 1);
	localparam int TYPE_BITS = 2;
	localparam int VALUE_BITS = 3;
	localparam int CHECK_BITS = 3;
	localparam int ENTRY_W = TYPE_BITS + VALUE_BITS;
	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;
	localparam int ACT_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 3;

	typedef logic [TYPE_BITS-1:0] type_t;
	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [CHECK_BITS-1:0] check_t;
	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [ACT_W-1:0] act_t;
	typedef logic [3:0] op_t;

	// result kinds
	localparam kind_t KIND_STATUS = 2'd0;
	localparam kind_t KIND_TX = 2'd1;
	localparam kind_t KIND_DELIV = 2'd2;
	localparam kind_t KIND_CHKERR = 2'd3;

	// input actions
	localparam act_t ACT_SEND = 2'd0;
	localparam act_t ACT_RX = 2'd1;
	localparam act_t ACT_POLL = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SYS_TYPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LISTEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR = 2'd2;

	localparam type_t RST_SYS_TYPE = 2'd0;
	localparam value_t RST_LISTEN = 3'd1;
	localparam value_t RST_ERROR = 3'd2;

	// datapath operations
	localparam op_t OP_NONE = 4'd0;
	localparam op_t OP_LATCH = 4'd1;
	localparam op_t OP_ERRINS = 4'd2;
	localparam op_t OP_APPEND = 4'd3;
	localparam op_t OP_OVRWR = 4'd4;
	localparam op_t OP_REWIND = 4'd5;
	localparam op_t OP_BSTART = 4'd6;
	localparam op_t OP_RDNEW = 4'd7;
	localparam op_t OP_RDTAIL = 4'd8;
	localparam op_t OP_POP = 4'd9;

	typedef struct packed {
		op_t op;
		logic emit;
		kind_t kind;
		logic tx_from_queue;
		logic last;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic rx_ok;
		logic rx_sys;
		logic rx_listen;
		logic rx_err;
		logic send_err;
		logic ovr;
		logic newest_match;
		logic q_empty;
		logic burst_last;
		logic out_free;
	} stat_t;

	function automatic check_t chk_of(type_t t, value_t v);
		logic [VALUE_BITS:0] sum;
		sum = (VALUE_BITS+1)'(t) + (VALUE_BITS+1)'(v);
		return CHECK_BITS'(sum >> 1);
	endfunction

	function automatic logic [BYTE_W-1:0] pack_byte(type_t t, value_t v);
		return {t, v, chk_of(t, v)};
	endfunction

endpackage
`default_nettype wire

// ===== src/polled_message_queue_link.sv =====
// polled one-byte message link with a 16-entry transmit ring
// input channel (in_valid/in_ready): one item per beat, carrying action,
//   msg_type, msg_value, override_same and rx_byte
// output channel (out_valid/out_ready): one result per beat; last marks the
//   final result of an item, a listening poll yields up to 8 tx beats
// config channel (cfg_valid/cfg_ready): cfg_index 0 system type code,
//   1 listening code, 2 error code; other indexes are ignored; always ready
// an item is latched in IDLE and decoded in DEC, and EMIT loads its result into the
//   output register; an override send passes OVR between DEC and EMIT (newest
//   entry is read first)
// a poll burst sends each entry by a tail read, then an output load that waits
//   while the output register is still full; the single entry-store read port
//   serves both the tail read and the override read
// one item is in flight at a time; in_ready is high only when idle
// reset: ring, pointers and burst state clear, registers return to 0, 1, 2
// receiver stall: the result waits in the output register and the
//   controller holds until it is taken
`default_nettype none
module polled_message_queue_link (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire plm_pkg::act_t                    action,
	input  wire plm_pkg::type_t                   msg_type,
	input  wire plm_pkg::value_t                  msg_value,
	input  wire logic                             override_same,
	input  wire logic [plm_pkg::BYTE_W-1:0]       rx_byte,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [plm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [plm_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output plm_pkg::kind_t                        kind,
	output logic [plm_pkg::BYTE_W-1:0]            tx_byte,
	output plm_pkg::type_t                        rx_type,
	output plm_pkg::value_t                       rx_value,
	output logic                                  overflow,
	output logic                                  last
);
	import plm_pkg::*;

	cmd_t cmd;   // controller to datapath operation
	stat_t st;   // datapath conditions back to the controller

	// registers are plain flops, a write never has to wait
	assign cfg_ready = 1'b1;

	plm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// ring, pointers, registers, decode of the latched item and output beat
	plm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.action        (action),
		.msg_type      (msg_type),
		.msg_value     (msg_value),
		.override_same (override_same),
		.rx_byte       (rx_byte),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.tx_byte       (tx_byte),
		.rx_type       (rx_type),
		.rx_value      (rx_value),
		.overflow      (overflow),
		.last          (last)
	);

endmodule
`default_nettype wire

// ===== src/plm_ctrl.sv =====
`default_nettype none
module plm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire plm_pkg::stat_t st,
	output plm_pkg::cmd_t      cmd
);
	import plm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC = 3'd1;
	localparam logic [2:0] S_OVR = 3'd2;
	localparam logic [2:0] S_EMIT = 3'd3;
	localparam logic [2:0] S_BCHK = 3'd4;
	localparam logic [2:0] S_BRD = 3'd5;

	logic [2:0] state_q, state_d;
	kind_t kind_q, kind_d;
	logic txq_q, txq_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		kind_d = kind_q;
		txq_d = txq_q;
		cmd = '0;
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LATCH;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_EMIT;
				kind_d = KIND_STATUS;
				txq_d = 1'b0;
				unique case (st.act)
					ACT_SEND: begin
						priority if (st.send_err) begin
							cmd.op = OP_ERRINS;
						end else if (st.ovr) begin
							cmd.op = OP_RDNEW;
							state_d = S_OVR;
						end else begin
							cmd.op = OP_APPEND;
						end
					end
					ACT_RX: begin
						priority if (!st.rx_ok) begin
							cmd.op = OP_ERRINS;
							kind_d = KIND_CHKERR;
						end else if (st.rx_sys && st.rx_listen) begin
							cmd.op = OP_BSTART;
							state_d = S_BCHK;
						end else if (st.rx_sys && st.rx_err) begin
							cmd.op = OP_REWIND;
						end else if (!st.rx_sys) begin
							kind_d = KIND_DELIV;
						end else begin
							kind_d = KIND_STATUS;
						end
					end
					ACT_POLL: begin
						kind_d = KIND_TX;
					end
					default: begin
						kind_d = KIND_STATUS;
					end
				endcase
			end
			S_OVR: begin
				// newest entry now in the read register
				cmd.op = st.newest_match ? OP_OVRWR : OP_APPEND;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = kind_q;
					cmd.tx_from_queue = txq_q;
					cmd.last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_BCHK: begin
				if (st.q_empty) begin
					kind_d = KIND_STATUS;
					txq_d = 1'b0;
					state_d = S_EMIT;
				end else begin
					cmd.op = OP_RDTAIL;
					state_d = S_BRD;
				end
			end
			S_BRD: begin
				if (st.out_free) begin
					cmd.op = OP_POP;
					cmd.emit = 1'b1;
					cmd.kind = KIND_TX;
					cmd.tx_from_queue = 1'b1;
					cmd.last = st.burst_last;
					state_d = st.burst_last ? S_IDLE : S_BCHK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= KIND_STATUS;
			txq_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q <= kind_d;
			txq_q <= txq_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/plm_dp.sv =====
`default_nettype none
module plm_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire plm_pkg::cmd_t                    cmd,
	output plm_pkg::stat_t                        st,
	input  wire plm_pkg::act_t                    action,
	input  wire plm_pkg::type_t                   msg_type,
	input  wire plm_pkg::value_t                  msg_value,
	input  wire logic                             override_same,
	input  wire logic [plm_pkg::BYTE_W-1:0]       rx_byte,
	input  wire logic                             cfg_valid,
	input  wire logic [plm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [plm_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output plm_pkg::kind_t                        kind,
	output logic [plm_pkg::BYTE_W-1:0]            tx_byte,
	output plm_pkg::type_t                        rx_type,
	output plm_pkg::value_t                       rx_value,
	output logic                                  overflow,
	output logic                                  last
);
	import plm_pkg::*;

	// configuration
	type_t sys_type_q;
	value_t listen_q, error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_type_q <= RST_SYS_TYPE;
			listen_q <= RST_LISTEN;
			error_q <= RST_ERROR;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_SYS_TYPE) sys_type_q <= TYPE_BITS'(cfg_data);
			if (cfg_index == CFG_LISTEN) listen_q <= VALUE_BITS'(cfg_data);
			if (cfg_index == CFG_ERROR) error_q <= VALUE_BITS'(cfg_data);
		end
	end

	// latched input item
	act_t act_q;
	type_t mt_q;
	value_t mv_q;
	logic ovr_q;
	logic [BYTE_W-1:0] rx_q;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LATCH) begin
			act_q <= action;
			mt_q <= msg_type;
			mv_q <= msg_value;
			ovr_q <= override_same;
			rx_q <= rx_byte;
		end
	end

	// received byte fields
	type_t rt;
	value_t rv;
	check_t rc;
	assign rc = rx_q[CHECK_BITS-1:0];
	assign rv = rx_q[CHECK_BITS +: VALUE_BITS];
	assign rt = rx_q[CHECK_BITS+VALUE_BITS +: TYPE_BITS];

	// pointers and burst count
	ptr_t head_q, tail_q, newest_q, bstart_q;
	logic [CNT_W-1:0] cnt_q;
	logic ovf_q;

	ptr_t tail_dec, head_inc, tail_inc, err_slot;
	logic err_full, app_full;
	assign tail_dec = tail_q - 1'b1;
	assign tail_inc = tail_q + 1'b1;
	assign head_inc = head_q + 1'b1;
	assign err_full = (tail_dec == head_q);
	assign err_slot = err_full ? tail_q : tail_dec;
	assign app_full = (head_inc == tail_q);

	// entry store with per-entry valid bits, unwritten entries read as zero
	logic [ENTRY_W-1:0] mem_q [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] vld_q;
	logic [ENTRY_W-1:0] rd_q;
	logic wr_en, rd_en;
	ptr_t wr_addr, rd_addr;
	logic [ENTRY_W-1:0] wr_data;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = head_q;
		wr_data = {mt_q, mv_q};
		unique case (cmd.op)
			OP_ERRINS: begin
				wr_en = 1'b1;
				wr_addr = err_slot;
				wr_data = {sys_type_q, error_q};
			end
			OP_OVRWR: begin
				wr_en = 1'b1;
				wr_addr = newest_q;
			end
			OP_APPEND: begin
				wr_en = !app_full;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign rd_en = (cmd.op == OP_RDNEW) || (cmd.op == OP_RDTAIL);
	assign rd_addr = (cmd.op == OP_RDNEW) ? newest_q : tail_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= vld_q[rd_addr] ? mem_q[rd_addr] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			newest_q <= '0;
			bstart_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_LATCH: ovf_q <= 1'b0;
				OP_ERRINS: begin
					tail_q <= err_slot;
					ovf_q <= err_full;
				end
				OP_APPEND: begin
					ovf_q <= app_full;
					if (!app_full) begin
						newest_q <= head_q;
						head_q <= head_inc;
					end
				end
				OP_OVRWR: begin
					if (tail_q == head_q) tail_q <= tail_dec;
				end
				OP_REWIND: tail_q <= bstart_q;
				OP_BSTART: begin
					bstart_q <= tail_q;
					cnt_q <= '0;
				end
				OP_POP: begin
					tail_q <= tail_inc;
					cnt_q <= cnt_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// status toward the controller
	assign st.act = act_q;
	assign st.rx_ok = (chk_of(rt, rv) == rc);
	assign st.rx_sys = (rt == sys_type_q);
	assign st.rx_listen = (rv == listen_q);
	assign st.rx_err = (rv == error_q);
	assign st.send_err = (mt_q == sys_type_q) && (mv_q == error_q);
	assign st.ovr = ovr_q;
	assign st.newest_match = (rd_q[VALUE_BITS +: TYPE_BITS] == mt_q);
	assign st.q_empty = (tail_q == head_q);
	assign st.burst_last = (cnt_q == CNT_W'(BURST_LIMIT - 1)) || (tail_inc == head_q);
	assign st.out_free = !out_valid || out_ready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind <= cmd.kind;
			last <= cmd.last;
			overflow <= (cmd.kind == KIND_TX) ? 1'b0 : ovf_q;
			if (cmd.kind == KIND_TX) begin
				tx_byte <= cmd.tx_from_queue ?
					pack_byte(rd_q[VALUE_BITS +: TYPE_BITS], rd_q[VALUE_BITS-1:0]) :
					pack_byte(sys_type_q, listen_q);
			end else begin
				tx_byte <= '0;
			end
			rx_type <= (cmd.kind == KIND_DELIV) ? rt : '0;
			rx_value <= (cmd.kind == KIND_DELIV) ? rv : '0;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("result loaded over an untaken one");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(BURST_LIMIT))
		else $error("burst count past limit");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_POP) |-> (tail_q != head_q))
		else $error("pop from empty queue");

	a_append_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_APPEND) && !app_full |=> (head_q == $past(head_inc)))
		else $error("head did not advance on append");

endmodule
`default_nettype wire

// ===== tb/plm_result_check.sv =====
`timescale 1ns / 1ps
module plm_result_check (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_ready,
	input  wire plm_pkg::act_t                  action,
	input  wire plm_pkg::type_t                 msg_type,
	input  wire plm_pkg::value_t                msg_value,
	input  wire logic                           override_same,
	input  wire logic [plm_pkg::BYTE_W-1:0]     rx_byte,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [plm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [plm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           out_valid,
	input  wire logic                           out_ready,
	input  wire plm_pkg::kind_t                 kind,
	input  wire logic [plm_pkg::BYTE_W-1:0]     tx_byte,
	input  wire plm_pkg::type_t                 rx_type,
	input  wire plm_pkg::value_t                rx_value,
	input  wire logic                           overflow,
	input  wire logic                           last,
	output int                                  mismatch_count,
	output int                                  pending
);
	import plm_pkg::*;

	typedef struct packed {
		type_t  t;
		value_t v;
	} slot_t;

	typedef struct packed {
		kind_t               kind;
		logic [BYTE_W-1:0]   tx;
		type_t               rt;
		value_t              rv;
		logic                ovf;
		logic                lst;
	} link_beat_t;

	slot_t ring [QUEUE_DEPTH];
	ptr_t wr_ptr, rd_ptr, newest_ptr, rewind_ptr;
	type_t sys_code;
	value_t listen_code, err_code;
	link_beat_t due_beats[$];

	function automatic logic [BYTE_W-1:0] frame_of(type_t t, value_t v);
		logic [VALUE_BITS:0] sum;
		sum = {1'b0, v} + {{(VALUE_BITS + 1 - TYPE_BITS){1'b0}}, t};
		return {t, v, check_t'(sum >> 1)};
	endfunction

	function automatic void await_beat(kind_t k, logic [BYTE_W-1:0] tx, type_t t, value_t v,
			logic ovf, logic lst);
		link_beat_t b;
		b.kind = k;
		b.tx = tx;
		b.rt = t;
		b.rv = v;
		b.ovf = ovf;
		b.lst = lst;
		due_beats.push_back(b);
	endfunction

	function automatic void store(ptr_t p, type_t t, value_t v);
		ring[p].t = t;
		ring[p].v = v;
	endfunction

	// queue a message, returns 1 when the ring was full
	function automatic logic ring_put(type_t t, value_t v, logic ovr);
		ptr_t slot;
		logic full;
		full = 1'b0;
		if (t == sys_code && v == err_code) begin
			// error message jumps the line, overwrites the oldest when full
			slot = rd_ptr - 1'b1;
			if (slot == wr_ptr) begin
				slot = rd_ptr;
				full = 1'b1;
			end
			store(slot, t, v);
			rd_ptr = slot;
		end else if (ovr && ring[newest_ptr].t == t) begin
			store(newest_ptr, t, v);
			if (rd_ptr == wr_ptr)
				rd_ptr = rd_ptr - 1'b1;
		end else if (ptr_t'(wr_ptr + 1'b1) != rd_ptr) begin
			store(wr_ptr, t, v);
			newest_ptr = wr_ptr;
			wr_ptr = wr_ptr + 1'b1;
		end else begin
			full = 1'b1;
		end
		return full;
	endfunction

	function automatic void derive_beats(act_t a, type_t mt, value_t mv, logic ovr,
			logic [BYTE_W-1:0] rx);
		type_t t;
		value_t v;
		ptr_t occ;
		logic f;
		int cnt;
		int i;
		case (a)
			ACT_SEND: begin
				f = ring_put(mt, mv, ovr);
				await_beat(KIND_STATUS, '0, '0, '0, f, 1'b1);
			end
			ACT_RX: begin
				v = rx[CHECK_BITS +: VALUE_BITS];
				t = rx[CHECK_BITS + VALUE_BITS +: TYPE_BITS];
				if (frame_of(t, v) != rx) begin
					f = ring_put(sys_code, err_code, 1'b0);
					await_beat(KIND_CHKERR, '0, '0, '0, f, 1'b1);
				end else if (t == sys_code && v == listen_code) begin
					rewind_ptr = rd_ptr;
					occ = wr_ptr - rd_ptr;
					cnt = occ;
					if (cnt > BURST_LIMIT)
						cnt = BURST_LIMIT;
					if (cnt == 0)
						await_beat(KIND_STATUS, '0, '0, '0, 1'b0, 1'b1);
					for (i = 0; i < cnt; i++) begin
						await_beat(KIND_TX, frame_of(ring[rd_ptr].t, ring[rd_ptr].v), '0, '0,
							1'b0, i == cnt - 1);
						rd_ptr = rd_ptr + 1'b1;
					end
				end else if (t == sys_code) begin
					if (v == err_code)
						rd_ptr = rewind_ptr;
					await_beat(KIND_STATUS, '0, '0, '0, 1'b0, 1'b1);
				end else begin
					await_beat(KIND_DELIV, '0, t, v, 1'b0, 1'b1);
				end
			end
			ACT_POLL: await_beat(KIND_TX, frame_of(sys_code, listen_code), '0, '0, 1'b0, 1'b1);
			default: await_beat(KIND_STATUS, '0, '0, '0, 1'b0, 1'b1);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		int k;
		link_beat_t exp;
		if (!arst_n) begin
			for (k = 0; k < QUEUE_DEPTH; k++)
				ring[k] = '0;
			wr_ptr = '0;
			rd_ptr = '0;
			newest_ptr = '0;
			rewind_ptr = '0;
			sys_code = RST_SYS_TYPE;
			listen_code = RST_LISTEN;
			err_code = RST_ERROR;
			due_beats.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SYS_TYPE: sys_code = type_t'(cfg_data);
					CFG_LISTEN: listen_code = cfg_data;
					CFG_ERROR: err_code = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (due_beats.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result beat kind %0d tx %02h", $time, kind,
							tx_byte);
				end else begin
					exp = due_beats.pop_front();
					if (kind !== exp.kind || tx_byte !== exp.tx || rx_type !== exp.rt ||
							rx_value !== exp.rv || overflow !== exp.ovf || last !== exp.lst) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: result mismatch kind/tx/type/value/ovf/last %0s",
								$time, $sformatf("exp %0d/%02h/%0d/%0d/%0b/%0b got %0d/%02h/%0d/%0d/%0b/%0b",
								exp.kind, exp.tx, exp.rt, exp.rv, exp.ovf, exp.lst,
								kind, tx_byte, rx_type, rx_value, overflow, last));
					end
				end
			end
			if (in_valid && in_ready)
				derive_beats(action, msg_type, msg_value, override_same, rx_byte);
			pending <= due_beats.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import plm_pkg::*;

	// action code with no meaning, the block answers with a status beat
	localparam act_t ACT_NOP = 2'd3;
	// register index past the list, ignored by the block
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	// long receiver hold-off so the block backs up into its input
	localparam int LONG_HOLD = 400;
	// bound on waiting for outstanding results
	localparam int DRAIN_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid, in_ready;
	act_t action;
	type_t msg_type;
	value_t msg_value;
	logic override_same;
	logic [BYTE_W-1:0] rx_byte;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic out_valid, out_ready;
	kind_t kind;
	logic [BYTE_W-1:0] tx_byte;
	type_t rx_type;
	value_t rx_value;
	logic overflow, last;

	int mismatch_count;
	int pending;

	// calm: no gaps on either side; hold_seq: bump to request a long hold-off
	bit calm = 1'b0;
	int hold_seq = 0;
	bit stuck = 1'b0;

	// current register settings, used to steer the stimulus
	type_t sys_code;
	value_t listen_code, err_code;

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	polled_message_queue_link uut (.*);

	plm_result_check result_check (.*);

	// mostly back-to-back, sometimes a few cycles, rarely a long gap
	function automatic int idle_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// well-formed line byte: type, value, checksum
	function automatic logic [BYTE_W-1:0] line_frame(type_t t, value_t v);
		logic [VALUE_BITS:0] sum;
		sum = {1'b0, v} + {2'b00, t};
		return {t, v, check_t'(sum >> 1)};
	endfunction

	// offer one input beat, return at the edge where it is taken
	task automatic offer_item(act_t a, type_t t, value_t v, logic o, logic [BYTE_W-1:0] b);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		msg_type <= t;
		msg_value <= v;
		override_same <= o;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// config beat; valid stays up across consecutive writes
	task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic write_codes(type_t s, value_t l, value_t e, logic spare);
		cfg_beat(CFG_SYS_TYPE, {1'b0, s});
		cfg_beat(CFG_LISTEN, l);
		cfg_beat(CFG_ERROR, e);
		// write to the unused index must change nothing
		if (spare)
			cfg_beat(CFG_SPARE, 3'b110);
		cfg_valid <= 1'b0;
		sys_code = s;
		listen_code = l;
		err_code = e;
	endtask

	// stop offering, wait for every expected result, then let the block settle
	task automatic drain();
		int waited;
		in_valid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending != 0)
			stuck = 1'b1;
		repeat (8) @(posedge clk);
	endtask

	// mostly well-formed traffic: sends, good line bytes with polls and rewinds,
	// a share of corrupted bytes, and the odd local poll or idle action
	task automatic random_item();
		int r;
		int pick;
		type_t t;
		value_t v;
		logic [BYTE_W-1:0] b;
		r = $urandom_range(0, 99);
		t = type_t'($urandom);
		v = value_t'($urandom);
		b = BYTE_W'($urandom);
		if (r < 42) begin
			if ($urandom_range(0, 9) == 0) begin
				t = sys_code;
				v = err_code;
			end
			offer_item(ACT_SEND, t, v, $urandom_range(0, 9) < 3, b);
		end else if (r < 92) begin
			if ($urandom_range(0, 99) >= 12) begin
				if ($urandom_range(0, 99) < 45) begin
					t = sys_code;
					pick = $urandom_range(0, 19);
					if (pick < 11)
						v = listen_code;
					else if (pick < 16)
						v = err_code;
				end
				b = line_frame(t, v);
			end
			offer_item(ACT_RX, type_t'($urandom), value_t'($urandom), 1'($urandom), b);
		end else begin
			offer_item(r < 96 ? ACT_POLL : ACT_NOP, t, v, 1'($urandom), b);
		end
	endtask

	// receiver: random stalls, plus a long counted hold-off on request
	initial begin : receiver
		int seen_hold;
		seen_hold = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seq != seen_hold) begin
				seen_hold = hold_seq;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat (idle_gap()) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		in_valid <= 1'b0;
		action <= ACT_SEND;
		msg_type <= '0;
		msg_value <= '0;
		override_same <= 1'b0;
		rx_byte <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		sys_code = RST_SYS_TYPE;
		listen_code = RST_LISTEN;
		err_code = RST_ERROR;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset register values
		// override on the empty ring right after reset: last slot gets resent
		offer_item(ACT_SEND, 2'd0, 3'd5, 1'b1, 8'h00);
		offer_item(ACT_RX, 2'd0, 3'd0, 1'b0, line_frame(RST_SYS_TYPE, RST_LISTEN));
		// poll on an empty ring
		offer_item(ACT_RX, 2'd3, 3'd7, 1'b1, line_frame(RST_SYS_TYPE, RST_LISTEN));
		offer_item(ACT_POLL, 2'd0, 3'd0, 1'b0, 8'h00);
		offer_item(ACT_NOP, 2'd3, 3'd7, 1'b1, 8'hff);
		offer_item(ACT_SEND, 2'd3, 3'd7, 1'b0, 8'h00);
		// override with matching type, then with a different type (appends)
		offer_item(ACT_SEND, 2'd3, 3'd0, 1'b1, 8'h00);
		offer_item(ACT_SEND, 2'd1, 3'd4, 1'b1, 8'h00);
		offer_item(ACT_RX, 2'd0, 3'd0, 1'b0, line_frame(RST_SYS_TYPE, RST_LISTEN));
		// partner reports an error: rewind and resend the last burst
		offer_item(ACT_RX, 2'd0, 3'd0, 1'b0, line_frame(RST_SYS_TYPE, RST_ERROR));
		offer_item(ACT_RX, 2'd0, 3'd0, 1'b0, line_frame(RST_SYS_TYPE, RST_LISTEN));
		// corrupted byte, then delivered messages at the field extremes
		offer_item(ACT_RX, 2'd0, 3'd0, 1'b0, 8'hff);
		offer_item(ACT_RX, 2'd0, 3'd0, 1'b0, line_frame(2'd3, 3'd7));
		offer_item(ACT_RX, 2'd0, 3'd0, 1'b0, line_frame(2'd1, 3'd0));
		// system message that is neither listening nor error is ignored
		offer_item(ACT_RX, 2'd0, 3'd0, 1'b0, 8'h00);
		// local error message goes in front
		offer_item(ACT_SEND, RST_SYS_TYPE, RST_ERROR, 1'b0, 8'h00);
		// fill the ring until appends are dropped
		repeat (16) offer_item(ACT_SEND, 2'd2, value_t'($urandom), 1'b0, 8'h00);
		// error message on a full ring overwrites the oldest entry
		offer_item(ACT_SEND, RST_SYS_TYPE, RST_ERROR, 1'b1, 8'h00);
		offer_item(ACT_RX, 2'd0, 3'd0, 1'b0, 8'h07);
		offer_item(ACT_RX, 2'd0, 3'd0, 1'b0, line_frame(RST_SYS_TYPE, RST_LISTEN));
		offer_item(ACT_RX, 2'd0, 3'd0, 1'b0, line_frame(RST_SYS_TYPE, RST_LISTEN));
		repeat (12) random_item();
		drain();

		// top codes, with a long receiver hold-off in the middle
		write_codes(2'd3, 3'd7, 3'd0, 1'b0);
		repeat (12) random_item();
		hold_seq++;
		repeat (20) random_item();
		drain();

		// spare index written too; first half runs without any gaps
		write_codes(2'd1, 3'd0, 3'd7, 1'b1);
		calm = 1'b1;
		repeat (16) random_item();
		calm = 1'b0;
		repeat (16) random_item();
		drain();

		// listening and error share one value: listening wins
		write_codes(2'd2, 3'd5, 3'd5, 1'b0);
		repeat (32) random_item();
		drain();

		write_codes(RST_SYS_TYPE, RST_LISTEN, RST_ERROR, 1'b0);
		repeat (16) random_item();
		drain();

		if (mismatch_count == 0 && !stuck)
			$display("[polled_message_queue_link] OK");
		else
			$display("[polled_message_queue_link] ERROR");
		$finish;
	end

	// backstop on a hung run
	initial begin
		#8_000_000;
		$display("[polled_message_queue_link] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
src/plm_pkg.sv
src/plm_ctrl.sv
src/plm_dp.sv
src/polled_message_queue_link.sv
tb/plm_result_check.sv
tb/tb.sv
